/* hw/rtl/sv7seg_pkg.sv */
// Shared constants, types and glyph table for the seven-segment formatter.
`timescale 1ns / 1ps

package sv7seg_pkg;

	// Display geometry and segment word width.
	localparam int DIGIT_COUNT = 6;
	localparam int SEG_W       = 8;
	localparam int READING_W   = 32;
	localparam int PLACES_W    = 3;
	localparam int CFG_DATA_W  = 3;

	// Magnitudes that fit the display stay below one million, so 20 bits suffice.
	localparam int VALUE_W     = 20;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 23;
	localparam int PROD_W      = VALUE_W + RECIP_W;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838861;

	// Most digits after the point, and the smallest magnitudes that no longer fit.
	localparam logic [PLACES_W-1:0]  MAX_PLACES     = 3'd5;
	localparam logic [READING_W-1:0] LIMIT_NO_SIGN  = 32'd1000000;
	localparam logic [READING_W-1:0] LIMIT_WITH_SIGN = 32'd100000;

	// Segment patterns, a..g at bits 0..6, dp at bit 7.
	localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
	localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
	localparam logic [SEG_W-1:0] SEG_DP    = 8'h80;
	localparam logic [SEG_W-1:0] SEG_L     = 8'h38;
	localparam logic [SEG_W-1:0] SEG_O     = 8'h5C;
	localparam logic [SEG_W-1:0] SEG_H     = 8'h76;
	localparam logic [SEG_W-1:0] SEG_I     = 8'h06;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_POINT_DIGITS = 1'b0,
		REG_SHOW_SIGN    = 1'b1
	} cfg_reg_t;

	// Word handed from one cell to the next.
	typedef struct packed {
		logic [VALUE_W-1:0]           value;
		logic [PLACES_W-1:0]          pt_left;
		logic                         pt_done;
		logic                         has_frac;
		logic                         sign_on;
		logic                         overflow;
		logic                         prev_shown;
		logic [2*SEG_W-1:0]           fill;
		logic [DIGIT_COUNT*SEG_W-1:0] segs;
	} cell_data_t;

	// Decimal digit to segment pattern.
	function automatic logic [SEG_W-1:0] digit_glyph(input logic [3:0] d);
		logic [SEG_W-1:0] g;
		case (d)
			4'd0:    g = 8'h3F;
			4'd1:    g = 8'h06;
			4'd2:    g = 8'h5B;
			4'd3:    g = 8'h4F;
			4'd4:    g = 8'h66;
			4'd5:    g = 8'h6D;
			4'd6:    g = 8'h7D;
			4'd7:    g = 8'h07;
			4'd8:    g = 8'h7F;
			4'd9:    g = 8'h6F;
			default: g = SEG_BLANK;
		endcase
		return g;
	endfunction

endpackage

/* hw/rtl/sv7seg_if.sv */
// Valid/ready channel interfaces for readings and segment words.
`timescale 1ns / 1ps

interface sv7seg_reading_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] reading;

	modport source (output valid, output reading, input ready);
	modport sink   (input valid, input reading, output ready);
endinterface

interface sv7seg_digits_if;
	logic       valid;
	logic       ready;
	logic [7:0] digit0_segments;
	logic [7:0] digit1_segments;
	logic [7:0] digit2_segments;
	logic [7:0] digit3_segments;
	logic [7:0] digit4_segments;
	logic [7:0] digit5_segments;

	modport source (
		output valid, output digit0_segments, output digit1_segments,
		output digit2_segments, output digit3_segments, output digit4_segments,
		output digit5_segments, input ready
	);
	modport sink (
		input valid, input digit0_segments, input digit1_segments,
		input digit2_segments, input digit3_segments, input digit4_segments,
		input digit5_segments, output ready
	);
endinterface

/* hw/rtl/sv7seg_entry.sv */
// Entry stage: sign, magnitude, point saturation and overflow check.
`timescale 1ns / 1ps

module sv7seg_entry
	import sv7seg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [READING_W-1:0] reading,
	input  logic [PLACES_W-1:0]  places,
	input  logic                 show_sign,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cell_data_t           out_data
);

	logic                 valid_q;
	cell_data_t           data_q;
	cell_data_t           data_d;
	logic                 negative;
	logic                 sign_on;
	logic                 overflow;
	logic [READING_W-1:0] magnitude;
	logic [PLACES_W-1:0]  places_sat;

	// Magnitude and the overflow test against a limit chosen by the sign.
	always_comb begin
		negative   = reading[READING_W-1];
		magnitude  = negative ? (READING_W'(0) - reading) : reading;
		places_sat = (places > MAX_PLACES) ? MAX_PLACES : places;
		sign_on    = negative && show_sign;
		// With a sign and the most fraction digits there is no room left.
		overflow   = (sign_on && (places_sat == MAX_PLACES)) ||
		             (magnitude >= (sign_on ? LIMIT_WITH_SIGN : LIMIT_NO_SIGN));
	end

	// Word for the first cell.
	always_comb begin
		data_d.value      = overflow ? '0 : magnitude[VALUE_W-1:0];
		data_d.pt_left    = places_sat;
		data_d.pt_done    = 1'b0;
		data_d.has_frac   = (places_sat != '0);
		data_d.sign_on    = sign_on;
		data_d.overflow   = overflow;
		data_d.prev_shown = 1'b1;
		if (!overflow) begin
			data_d.fill = '0;
		end else if (negative) begin
			data_d.fill = {SEG_L, SEG_O};
		end else begin
			data_d.fill = {SEG_H, SEG_I};
		end
		data_d.segs = '0;
	end

	assign in_ready = !valid_q || out_ready;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= data_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

/* hw/rtl/sv7seg_cell.sv */
// One digit cell: divides by ten and shifts its segment pattern into the word.
`timescale 1ns / 1ps

module sv7seg_cell
	import sv7seg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  cell_data_t in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output cell_data_t out_data
);

	logic               valid_q;
	cell_data_t         data_q;
	cell_data_t         data_d;
	logic [PROD_W-1:0]  prod;
	logic [VALUE_W-1:0] quot;
	logic [VALUE_W-1:0] times_ten;
	logic [VALUE_W-1:0] rem_full;
	logic               shown;
	logic               dp_here;
	logic [SEG_W-1:0]   glyph;

	// Divide by ten with a reciprocal multiply; exact below about four million.
	always_comb begin
		prod      = PROD_W'(in_data.value) * PROD_W'(RECIP_TEN);
		quot      = VALUE_W'(prod[PROD_W-1:RECIP_SHIFT]);
		times_ten = (quot << 3) + (quot << 1);
		rem_full  = in_data.value - times_ten;
	end

	// Pick this position's pattern.
	always_comb begin
		shown   = !in_data.pt_done || (in_data.value != '0);
		dp_here = !in_data.pt_done && (in_data.pt_left == '0) && in_data.has_frac;
		if (in_data.overflow) begin
			glyph = in_data.fill[SEG_W-1:0];
		end else if (shown) begin
			glyph = digit_glyph(rem_full[3:0]) | (dp_here ? SEG_DP : SEG_BLANK);
		end else if (in_data.sign_on && in_data.prev_shown) begin
			glyph = SEG_MINUS;
		end else begin
			glyph = SEG_BLANK;
		end
	end

	// Word for the next cell; the pattern enters at the left end of the row.
	always_comb begin
		data_d            = in_data;
		data_d.value      = quot;
		data_d.pt_left    = in_data.pt_left - 1'b1;
		data_d.pt_done    = in_data.pt_done || (in_data.pt_left == '0);
		data_d.prev_shown = shown;
		data_d.fill       = {SEG_BLANK, in_data.fill[2*SEG_W-1:SEG_W]};
		data_d.segs       = {glyph, in_data.segs[DIGIT_COUNT*SEG_W-1:SEG_W]};
	end

	assign in_ready = !valid_q || out_ready;

	// Cell valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Cell payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= data_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

/* hw/rtl/signed_value_to_seven_segment_top.sv */
// Signed reading to six seven-segment patterns: entry stage and a row of digit cells.
// An accepted reading passes the entry stage and one cell per display position, the last
// cell being the output register; each cell divides by ten once and hands on its word.
// Throughput: one word per cycle unless the output stalls.
// Every stage has its own valid flag, so gaps in the row fill while the output stalls.
// Reset clears all valid flags, sets the fraction digit count to 0 and show_sign to 1.
`timescale 1ns / 1ps

module signed_value_to_seven_segment_top
	import sv7seg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	sv7seg_reading_if.sink        sample_ch,
	sv7seg_digits_if.source       digits_ch
);

	logic [PLACES_W-1:0] point_digits_q;
	logic                show_sign_q;
	logic                stage_valid [0:DIGIT_COUNT];
	logic                stage_ready [0:DIGIT_COUNT];
	cell_data_t          stage_data  [0:DIGIT_COUNT];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_digits_q <= '0;
			show_sign_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_POINT_DIGITS: point_digits_q <= cfg_wdata[PLACES_W-1:0];
				REG_SHOW_SIGN:    show_sign_q    <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	// Sign, magnitude and overflow.
	sv7seg_entry u_entry (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_ch.valid),
		.in_ready  (sample_ch.ready),
		.reading   (sample_ch.reading),
		.places    (point_digits_q),
		.show_sign (show_sign_q),
		.out_valid (stage_valid[0]),
		.out_ready (stage_ready[0]),
		.out_data  (stage_data[0])
	);

	// Row of digit cells, rightmost position first.
	for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
		sv7seg_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_valid[i]),
			.in_ready  (stage_ready[i]),
			.in_data   (stage_data[i]),
			.out_valid (stage_valid[i+1]),
			.out_ready (stage_ready[i+1]),
			.out_data  (stage_data[i+1])
		);
	end

	// Output word from the last cell.
	assign digits_ch.valid           = stage_valid[DIGIT_COUNT];
	assign stage_ready[DIGIT_COUNT]  = digits_ch.ready;
	assign digits_ch.digit0_segments = stage_data[DIGIT_COUNT].segs[6*SEG_W-1:5*SEG_W];
	assign digits_ch.digit1_segments = stage_data[DIGIT_COUNT].segs[5*SEG_W-1:4*SEG_W];
	assign digits_ch.digit2_segments = stage_data[DIGIT_COUNT].segs[4*SEG_W-1:3*SEG_W];
	assign digits_ch.digit3_segments = stage_data[DIGIT_COUNT].segs[3*SEG_W-1:2*SEG_W];
	assign digits_ch.digit4_segments = stage_data[DIGIT_COUNT].segs[2*SEG_W-1:SEG_W];
	assign digits_ch.digit5_segments = stage_data[DIGIT_COUNT].segs[SEG_W-1:0];

`ifndef ASSERT_OFF
	// At most one decimal point is lit in a word.
	a_one_dp: assert property (@(posedge clk) disable iff (!arst_n)
		digits_ch.valid |-> $countones({digits_ch.digit0_segments[7],
			digits_ch.digit1_segments[7], digits_ch.digit2_segments[7],
			digits_ch.digit3_segments[7], digits_ch.digit4_segments[7],
			digits_ch.digit5_segments[7]}) <= 1)
		else $error("more than one decimal point lit");

	// The point is only lit with fraction digits, so never on the rightmost position.
	a_dp_not_right: assert property (@(posedge clk) disable iff (!arst_n)
		digits_ch.valid |-> !digits_ch.digit5_segments[7])
		else $error("decimal point on rightmost position");

	// At most one minus sign in a word.
	a_one_minus: assert property (@(posedge clk) disable iff (!arst_n)
		digits_ch.valid |-> $countones({digits_ch.digit0_segments == SEG_MINUS,
			digits_ch.digit1_segments == SEG_MINUS,
			digits_ch.digit2_segments == SEG_MINUS,
			digits_ch.digit3_segments == SEG_MINUS,
			digits_ch.digit4_segments == SEG_MINUS,
			digits_ch.digit5_segments == SEG_MINUS}) <= 1)
		else $error("more than one minus sign");

	// Input backpressure only when the output is stalled.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ch.ready |-> (digits_ch.valid && !digits_ch.ready))
		else $error("input stalled without output stall");
`endif

endmodule

/* tb/signed_value_to_seven_segment_checker.sv */
// Checker for the seven-segment formatter: predicts each display word and compares it.
`timescale 1ns / 1ps

module signed_value_to_seven_segment_checker
	import sv7seg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	sv7seg_reading_if             sample_ch,
	sv7seg_digits_if              digits_ch,
	output int                    mismatch_count,
	output int                    patterns_in_flight
);

	// One display word, position 0 being the leftmost.
	typedef logic [DIGIT_COUNT-1:0][SEG_W-1:0] seg_row_t;

	localparam logic [SEG_W-1:0] NUMERAL_SHAPES [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	logic [PLACES_W-1:0] places_cfg;
	logic                sign_cfg;
	seg_row_t            pending_patterns [$];

	// Works out the segment word that a reading should produce under the given settings.
	function automatic seg_row_t format_reading(logic [READING_W-1:0] raw,
			logic [PLACES_W-1:0] places_reg, logic sign_reg);
		seg_row_t            row;
		logic                negative;
		logic [READING_W-1:0] magnitude;
		logic [READING_W-1:0] whole;
		logic [READING_W-1:0] divisor;
		int                  places;
		int                  int_digits;
		int                  needed;
		int                  i;
		bit                  sign_on;

		negative  = raw[READING_W-1];
		magnitude = negative ? (32'd0 - raw) : raw;
		// Too many places saturate so that one integer digit always remains.
		places = (int'(places_reg) > DIGIT_COUNT - 1) ? DIGIT_COUNT - 1 : int'(places_reg);
		divisor = 32'd1;
		for (i = 0; i < places; i++) begin
			divisor = divisor * 32'd10;
		end
		int_digits = 1;
		if (magnitude >= divisor) begin
			int_digits = 0;
			whole = magnitude / divisor;
			while (whole != 0) begin
				int_digits++;
				whole = whole / 32'd10;
			end
		end
		sign_on = negative && sign_reg;
		needed  = int_digits + places + (sign_on ? 1 : 0);
		row     = '0;

		if (needed > DIGIT_COUNT) begin
			// Overflow shows Lo or HI in the two rightmost positions, whatever the sign option.
			row[DIGIT_COUNT-2] = negative ? SEG_L : SEG_H;
			row[DIGIT_COUNT-1] = negative ? SEG_O : SEG_I;
		end else begin
			if (sign_on) begin
				row[DIGIT_COUNT-needed] = SEG_MINUS;
			end
			for (i = 0; i < int_digits + places; i++) begin
				row[DIGIT_COUNT-1-i] = NUMERAL_SHAPES[magnitude % 32'd10];
				magnitude = magnitude / 32'd10;
			end
			if (places != 0) begin
				row[DIGIT_COUNT-1-places] = row[DIGIT_COUNT-1-places] | SEG_DP;
			end
		end
		return row;
	endfunction

	// Watch both channels and the register port at every rising edge.
	always @(posedge clk) begin
		seg_row_t got;
		seg_row_t want;
		if (!arst_n) begin
			places_cfg = '0;
			sign_cfg   = 1'b1;
			pending_patterns.delete();
		end else begin
			// A newly accepted reading is predicted with the settings in force before this edge.
			if (sample_ch.valid && sample_ch.ready) begin
				pending_patterns.push_back(format_reading(sample_ch.reading, places_cfg,
					sign_cfg));
			end

			// A delivered word is compared with the oldest prediction, position by position.
			if (digits_ch.valid && digits_ch.ready) begin
				got[0] = digits_ch.digit0_segments;
				got[1] = digits_ch.digit1_segments;
				got[2] = digits_ch.digit2_segments;
				got[3] = digits_ch.digit3_segments;
				got[4] = digits_ch.digit4_segments;
				got[5] = digits_ch.digit5_segments;
				if (pending_patterns.size() == 0) begin
					$error("display word %h arrived with no reading outstanding", got);
					mismatch_count++;
				end else begin
					want = pending_patterns.pop_front();
					for (int i = 0; i < DIGIT_COUNT; i++) begin
						if (got[i] !== want[i]) begin
							$error("digit%0d_segments: expected %02h, actual %02h",
								i, want[i], got[i]);
							mismatch_count++;
						end
					end
				end
			end

			// Register writes take effect for readings accepted after this edge.
			if (cfg_we) begin
				if (cfg_index == REG_POINT_DIGITS) begin
					places_cfg = cfg_wdata[PLACES_W-1:0];
				end else if (cfg_index == REG_SHOW_SIGN) begin
					sign_cfg = cfg_wdata[0];
				end
			end
		end
		patterns_in_flight = pending_patterns.size();
	end

endmodule

/* tb/signed_value_to_seven_segment_top_tb.sv */
// Testbench top for the seven-segment formatter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module signed_value_to_seven_segment_top_tb
	import sv7seg_pkg::*;
();

	localparam int SETTING_COUNT  = 10;
	localparam int READINGS_EACH  = 55;
	localparam int STALL_LIMIT    = 3000;
	localparam int LONG_HOLD      = 160;
	localparam int PRESSURE_PHASE = 2;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [0:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int mismatch_count;
	int patterns_in_flight;

	// Handshake shaping shared between the stimulus and the receiver.
	bit sender_idle_en;
	bit receiver_idle_en;
	int long_hold_req;

	// Register settings per phase; the extremes and the saturating values are included.
	int unsigned places_plan [SETTING_COUNT] = '{5, 5, 7, 6, 3, 1, 2, 4, 0, 0};
	bit          sign_plan   [SETTING_COUNT] = '{1, 0, 1, 0, 1, 0, 1, 0, 0, 1};

	logic [READING_W-1:0] corner_readings [16] = '{
		32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, 32'd123456, -32'sd78901,
		32'd999999, 32'd1000000, -32'sd99999, -32'sd100000, 32'h7FFFFFFF, 32'h80000000,
		32'd987654, -32'sd12345
	};

	sv7seg_reading_if sample_ch ();
	sv7seg_digits_if  digits_ch ();

	signed_value_to_seven_segment_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_ch),
		.digits_ch (digits_ch)
	);

	signed_value_to_seven_segment_checker display_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.sample_ch          (sample_ch),
		.digits_ch          (digits_ch),
		.mismatch_count     (mismatch_count),
		.patterns_in_flight (patterns_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offers one reading, called at a falling edge; returns at the falling edge after acceptance.
	task automatic offer_reading(input logic [READING_W-1:0] value);
		int gap;
		if (sender_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.reading <= value;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering and waits until every display word has come back.
	task automatic drain_words();
		sample_ch.valid <= 1'b0;
		while (patterns_in_flight != 0) @(negedge clk);
	endtask

	// Writes both registers on consecutive edges; the block is idle at this point.
	task automatic write_settings(input int unsigned places, input bit sign_on);
		cfg_we    <= 1'b1;
		cfg_index <= REG_POINT_DIGITS;
		cfg_wdata <= places[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_index <= REG_SHOW_SIGN;
		// The upper data bits are junk that the sign option must ignore.
		cfg_wdata <= {2'($urandom_range(0, 3)), sign_on};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Draws a reading: digit counts around the display width, powers of ten, small values, extremes and full range.
	function automatic logic [READING_W-1:0] pick_reading();
		logic [READING_W-1:0] value;
		longint              span;
		int                  n;
		span = 1;
		case ($urandom_range(0, 9))
			0, 1: value = $urandom;
			2, 3, 4, 5: begin
				n = $urandom_range(1, 7);
				repeat (n - 1) span = span * 10;
				value = (n == 1) ? $urandom_range(0, 9) :
					$urandom_range(int'(span), int'(span * 10 - 1));
				if ($urandom_range(0, 1) == 1) value = 32'd0 - value;
			end
			6, 7: begin
				repeat ($urandom_range(0, 7)) span = span * 10;
				value = 32'(span) + $urandom_range(0, 2) - 1;
				if ($urandom_range(0, 1) == 1) value = 32'd0 - value;
			end
			8: begin
				value = $urandom_range(0, 99);
				if ($urandom_range(0, 1) == 1) value = 32'd0 - value;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: value = 32'h7FFFFFFF;
					1: value = 32'h80000000;
					2: value = 32'hFFFFFFFF;
					default: value = 32'd0;
				endcase
			end
		endcase
		return value;
	endfunction

	// Receiver: random stall bursts with free-running stretches, plus one long hold-off.
	initial begin
		int stall_left;
		int free_left;
		digits_ch.ready = 1'b0;
		stall_left = 0;
		free_left  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req != 0) begin
				stall_left    = long_hold_req;
				long_hold_req = 0;
			end else if (stall_left == 0 && free_left == 0 && receiver_idle_en) begin
				if ($urandom_range(0, 2) == 0) begin
					free_left = $urandom_range(10, 40);
				end else begin
					stall_left = $urandom_range(1, 12);
					free_left  = $urandom_range(0, 8);
				end
			end
			if (stall_left > 0) begin
				digits_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				digits_ch.ready <= 1'b1;
				if (free_left > 0) free_left--;
			end
		end
	end

	// Watchdog: ends the run when neither channel moves a word for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (digits_ch.valid && digits_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Stimulus: reset, corner readings at reset settings, then one random phase per setting.
	initial begin
		cfg_we            = 1'b0;
		cfg_index         = REG_POINT_DIGITS;
		cfg_wdata         = '0;
		sample_ch.valid   = 1'b0;
		sample_ch.reading = '0;
		sender_idle_en    = 1'b1;
		receiver_idle_en  = 1'b1;
		long_hold_req     = 0;
		arst_n            = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (corner_readings[k]) begin
			offer_reading(corner_readings[k]);
		end

		for (int ph = 0; ph < SETTING_COUNT; ph++) begin
			drain_words();
			write_settings(places_plan[ph], sign_plan[ph]);
			// The final phase runs without idling on either side.
			if (ph == SETTING_COUNT - 1) begin
				sender_idle_en   = 1'b0;
				receiver_idle_en = 1'b0;
			end
			// Hold the receiver off while the sender keeps offering, so the row fills and stalls.
			if (ph == PRESSURE_PHASE) begin
				sender_idle_en = 1'b0;
				long_hold_req  = LONG_HOLD;
			end
			for (int k = 0; k < READINGS_EACH; k++) begin
				if (ph == PRESSURE_PHASE && k == 40) sender_idle_en = 1'b1;
				offer_reading(pick_reading());
			end
		end

		drain_words();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && patterns_in_flight == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/sv7seg_pkg.sv
hw/rtl/sv7seg_if.sv
hw/rtl/sv7seg_entry.sv
hw/rtl/sv7seg_cell.sv
hw/rtl/signed_value_to_seven_segment_top.sv
tb/signed_value_to_seven_segment_checker.sv
tb/signed_value_to_seven_segment_top_tb.sv
